@@ hdl/otx_pkg.sv @@
package otx_pkg;

    // Frame layout. Each field is placed MSB first, sender at the lowest frame positions.
    localparam int SENDER_BITS  = 7;
    localparam int TARGET_BITS  = 7;
    localparam int PAYLOAD_BITS = 17;
    localparam int FRAME_BITS   = 32;

    // Every data pulse pair covers one frame position.
    localparam int SYM_W = $clog2(2 * FRAME_BITS);
    localparam int POS_W = SYM_W - 1;
    localparam logic [SYM_W-1:0] SYM_LAST = SYM_W'(2 * FRAME_BITS - 1);

    localparam int TICK_W = 16;
    localparam int CFG_IDX_W = 3;

    // Stream payload widths, rounded up to whole bytes.
    localparam int IN_FIELDS_W = SENDER_BITS + TARGET_BITS + PAYLOAD_BITS;
    localparam int IN_DATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_DATA_W  = 8;

    localparam logic CMD_TICK  = 1'b0;
    localparam logic CMD_START = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_PULSE_HIGH   = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_ONE_LOW      = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_ZERO_LOW     = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_LATCH_HIGH   = CFG_IDX_W'(3);
    localparam logic [CFG_IDX_W-1:0] REG_LATCH1_LOW   = CFG_IDX_W'(4);
    localparam logic [CFG_IDX_W-1:0] REG_LATCH2_LOW   = CFG_IDX_W'(5);

    typedef enum logic [7:0] {
        PH_IDLE       = 8'b0000_0001,
        PH_NOISE      = 8'b0000_0010,
        PH_LATCH1_LOW = 8'b0000_0100,
        PH_GAP_HIGH   = 8'b0000_1000,
        PH_LATCH2_LOW = 8'b0001_0000,
        PH_DATA_HIGH  = 8'b0010_0000,
        PH_DATA_LOW   = 8'b0100_0000,
        PH_TRAILER    = 8'b1000_0000
    } t_phase;

    typedef struct packed {
        logic [TICK_W-1:0] pulse_high;
        logic [TICK_W-1:0] one_low;
        logic [TICK_W-1:0] zero_low;
        logic [TICK_W-1:0] latch_high;
        logic [TICK_W-1:0] latch1_low;
        logic [TICK_W-1:0] latch2_low;
    } t_cfg;

    typedef struct packed {
        logic line_level;
        logic busy_res;
        logic frame_done;
    } t_result;

    function automatic logic [FRAME_BITS-1:0] pack_frame(
        input logic [SENDER_BITS-1:0]  sender,
        input logic [TARGET_BITS-1:0]  target,
        input logic [PAYLOAD_BITS-1:0] payload
    );
        logic [FRAME_BITS-1:0] f;
        f = '0;
        for (int i = 0; i < SENDER_BITS; i++) begin
            if (i < FRAME_BITS) begin
                f[i] = sender[SENDER_BITS-1-i];
            end
        end
        for (int i = 0; i < TARGET_BITS; i++) begin
            if (SENDER_BITS + i < FRAME_BITS) begin
                f[SENDER_BITS+i] = target[TARGET_BITS-1-i];
            end
        end
        for (int i = 0; i < PAYLOAD_BITS; i++) begin
            if (SENDER_BITS + TARGET_BITS + i < FRAME_BITS) begin
                f[SENDER_BITS+TARGET_BITS+i] = payload[PAYLOAD_BITS-1-i];
            end
        end
        return f;
    endfunction

endpackage

@@ hdl/otx_cfg_regs.sv @@
module otx_cfg_regs (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_wr,
    input  logic [otx_pkg::CFG_IDX_W-1:0]    i_index,
    input  logic [otx_pkg::TICK_W-1:0]       i_data,
    output otx_pkg::t_cfg                    o_cfg
);

    otx_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.pulse_high <= otx_pkg::TICK_W'(310);
            r_cfg.one_low    <= otx_pkg::TICK_W'(1340);
            r_cfg.zero_low   <= otx_pkg::TICK_W'(310);
            r_cfg.latch_high <= otx_pkg::TICK_W'(275);
            r_cfg.latch1_low <= otx_pkg::TICK_W'(9900);
            r_cfg.latch2_low <= otx_pkg::TICK_W'(2675);
        end else if (i_wr) begin
            unique case (i_index)
                otx_pkg::REG_PULSE_HIGH: r_cfg.pulse_high <= i_data;
                otx_pkg::REG_ONE_LOW:    r_cfg.one_low    <= i_data;
                otx_pkg::REG_ZERO_LOW:   r_cfg.zero_low   <= i_data;
                otx_pkg::REG_LATCH_HIGH: r_cfg.latch_high <= i_data;
                otx_pkg::REG_LATCH1_LOW: r_cfg.latch1_low <= i_data;
                otx_pkg::REG_LATCH2_LOW: r_cfg.latch2_low <= i_data;
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

@@ hdl/otx_sequencer.sv @@
module otx_sequencer (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_step,
    input  logic                              i_cmd,
    input  logic [otx_pkg::SENDER_BITS-1:0]   i_sender_id,
    input  logic [otx_pkg::TARGET_BITS-1:0]   i_target_id,
    input  logic [otx_pkg::PAYLOAD_BITS-1:0]  i_payload,
    input  otx_pkg::t_cfg                     i_cfg,
    output otx_pkg::t_result                  o_res
);

    otx_pkg::t_phase                      r_phase, n_phase;
    logic [otx_pkg::SYM_W-1:0]            r_sym, n_sym;
    logic [otx_pkg::TICK_W-1:0]           r_tick, n_tick;
    logic                                 r_line, n_line;
    logic [otx_pkg::FRAME_BITS-1:0]       r_frame, n_frame;

    logic [otx_pkg::TICK_W-1:0]           seg_len;
    logic [otx_pkg::TICK_W-1:0]           seg_raw;
    logic                                 pulse_bit;
    logic                                 seg_end;
    logic                                 done;

    // The odd symbol of each pair sends the complement of the frame bit.
    assign pulse_bit = r_frame[r_sym[otx_pkg::SYM_W-1:1]] ^ r_sym[0];

    always_comb begin
        unique case (r_phase)
            otx_pkg::PH_NOISE,
            otx_pkg::PH_GAP_HIGH,
            otx_pkg::PH_TRAILER:    seg_raw = i_cfg.latch_high;
            otx_pkg::PH_LATCH1_LOW: seg_raw = i_cfg.latch1_low;
            otx_pkg::PH_LATCH2_LOW: seg_raw = i_cfg.latch2_low;
            otx_pkg::PH_DATA_HIGH:  seg_raw = i_cfg.pulse_high;
            otx_pkg::PH_DATA_LOW:   seg_raw = pulse_bit ? i_cfg.one_low : i_cfg.zero_low;
            default:                seg_raw = otx_pkg::TICK_W'(1);
        endcase
        // A zero length behaves like a single tick.
        seg_len = (seg_raw == '0) ? otx_pkg::TICK_W'(1) : seg_raw;
    end

    assign seg_end = ({1'b0, r_tick} + 17'd1) >= {1'b0, seg_len};

    always_comb begin
        n_phase = r_phase;
        n_sym   = r_sym;
        n_tick  = r_tick;
        n_line  = r_line;
        n_frame = r_frame;
        done    = 1'b0;
        if (i_step) begin
            if (i_cmd == otx_pkg::CMD_START) begin
                if (r_phase == otx_pkg::PH_IDLE) begin
                    n_frame = otx_pkg::pack_frame(i_sender_id, i_target_id, i_payload);
                    n_sym   = '0;
                    n_tick  = '0;
                    n_phase = otx_pkg::PH_NOISE;
                    n_line  = 1'b1;
                end
            end else if (r_phase != otx_pkg::PH_IDLE) begin
                if (seg_end) begin
                    n_tick = '0;
                    unique case (r_phase)
                        otx_pkg::PH_NOISE: begin
                            n_phase = otx_pkg::PH_LATCH1_LOW;
                            n_line  = 1'b0;
                        end
                        otx_pkg::PH_LATCH1_LOW: begin
                            n_phase = otx_pkg::PH_GAP_HIGH;
                            n_line  = 1'b1;
                        end
                        otx_pkg::PH_GAP_HIGH: begin
                            n_phase = otx_pkg::PH_LATCH2_LOW;
                            n_line  = 1'b0;
                        end
                        otx_pkg::PH_LATCH2_LOW: begin
                            n_phase = otx_pkg::PH_DATA_HIGH;
                            n_sym   = '0;
                            n_line  = 1'b1;
                        end
                        otx_pkg::PH_DATA_HIGH: begin
                            n_phase = otx_pkg::PH_DATA_LOW;
                            n_line  = 1'b0;
                        end
                        otx_pkg::PH_DATA_LOW: begin
                            if (r_sym == otx_pkg::SYM_LAST) begin
                                n_phase = otx_pkg::PH_TRAILER;
                                n_sym   = '0;
                            end else begin
                                n_phase = otx_pkg::PH_DATA_HIGH;
                                n_sym   = r_sym + 1'b1;
                            end
                            n_line = 1'b1;
                        end
                        default: begin
                            n_phase = otx_pkg::PH_IDLE;
                            n_line  = 1'b0;
                            done    = 1'b1;
                        end
                    endcase
                end else begin
                    n_tick = r_tick + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= otx_pkg::PH_IDLE;
            r_sym   <= '0;
            r_tick  <= '0;
            r_line  <= 1'b0;
            r_frame <= '0;
        end else begin
            r_phase <= n_phase;
            r_sym   <= n_sym;
            r_tick  <= n_tick;
            r_line  <= n_line;
            r_frame <= n_frame;
        end
    end

    assign o_res.line_level = n_line;
    assign o_res.busy_res   = (n_phase != otx_pkg::PH_IDLE);
    assign o_res.frame_done = done;

    a_idle_line_low: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == otx_pkg::PH_IDLE) |-> !r_line)
        else $error("line is high while the transmitter is idle");

    a_idle_tick_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == otx_pkg::PH_IDLE) |-> (r_tick == '0))
        else $error("tick counter not cleared while idle");

    a_sym_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sym <= otx_pkg::SYM_LAST)
        else $error("symbol index ran past the last data pulse");

    a_done_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && done) |=> (r_phase == otx_pkg::PH_IDLE))
        else $error("frame done reported without returning to idle");

endmodule

@@ hdl/ook_pulse_frame_transmitter.sv @@
// Channel   Direction  Handshake                    Payload
// s stream  in         i_s_tvalid / o_s_tready      tdata: sender, target, payload; tuser: cmd
// m stream  out        o_m_tvalid / i_m_tready      tdata: line_level, busy_res; tlast: done
// cfg write in         i_cfg_valid / o_cfg_ready    i_cfg_index, i_cfg_data
//
// Every accepted input transaction yields exactly one output transaction, which is
// registered and valid from the cycle after acceptance; a new item can be taken every
// cycle while the output register is not stalled. The rate is set by the single tick
// counter compare and the phase update, both of which are combinational.
// Reset is synchronous and active low; it restores the timing registers and
// returns the line to idle low. The input side stalls only while the output
// register holds a result that the downstream side has not taken.
module ook_pulse_frame_transmitter (
    input  logic                              i_clk,
    input  logic                              i_rst_n,

    input  logic                              i_s_tvalid,
    output logic                              o_s_tready,
    // Bits from lowest: sender_id [6:0], target_id [13:7], payload [30:14], zero pad.
    input  logic [otx_pkg::IN_DATA_W-1:0]     i_s_tdata,
    // Bit 0: cmd (0 = tick, 1 = start a frame).
    input  logic                              i_s_tuser,

    output logic                              o_m_tvalid,
    input  logic                              i_m_tready,
    // Bits from lowest: line_level, busy_res, zero pad.
    output logic [otx_pkg::OUT_DATA_W-1:0]    o_m_tdata,
    output logic                              o_m_tlast,

    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [otx_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [otx_pkg::TICK_W-1:0]        i_cfg_data
);

    localparam int TGT_LO = otx_pkg::SENDER_BITS;
    localparam int PAY_LO = otx_pkg::SENDER_BITS + otx_pkg::TARGET_BITS;

    otx_pkg::t_cfg    cfg;
    otx_pkg::t_result step_res;
    otx_pkg::t_result r_res;
    logic             r_out_valid;
    logic             s_accept;

    // Always ready; the user issues writes only while idle; the block does not enforce it.
    assign o_cfg_ready = 1'b1;

    otx_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (i_cfg_valid),
        .i_index (i_cfg_index),
        .i_data  (i_cfg_data),
        .o_cfg   (cfg)
    );

    // The output register frees up in the same cycle that its transaction completes,
    // so back to back items flow without a bubble.
    assign o_s_tready = !r_out_valid || i_m_tready;
    assign s_accept   = i_s_tvalid && o_s_tready;

    otx_sequencer u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (s_accept),
        .i_cmd       (i_s_tuser),
        .i_sender_id (i_s_tdata[otx_pkg::SENDER_BITS-1:0]),
        .i_target_id (i_s_tdata[TGT_LO +: otx_pkg::TARGET_BITS]),
        .i_payload   (i_s_tdata[PAY_LO +: otx_pkg::PAYLOAD_BITS]),
        .i_cfg       (cfg),
        .o_res       (step_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s_accept) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Result payload carries no reset; it is qualified by the valid flag.
    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_res <= step_res;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {{(otx_pkg::OUT_DATA_W-2){1'b0}}, r_res.busy_res, r_res.line_level};
    assign o_m_tlast  = r_res.frame_done;

endmodule

@@ verif/ook_pulse_frame_transmitter_tb.sv @@
module ook_pulse_frame_transmitter_tb;

    // Power-on values of the six timing registers, in ticks.
    localparam logic [otx_pkg::TICK_W-1:0] RST_PULSE_HIGH = 16'd310;
    localparam logic [otx_pkg::TICK_W-1:0] RST_ONE_LOW    = 16'd1340;
    localparam logic [otx_pkg::TICK_W-1:0] RST_ZERO_LOW   = 16'd310;
    localparam logic [otx_pkg::TICK_W-1:0] RST_LATCH_HIGH = 16'd275;
    localparam logic [otx_pkg::TICK_W-1:0] RST_LATCH1_LOW = 16'd9900;
    localparam logic [otx_pkg::TICK_W-1:0] RST_LATCH2_LOW = 16'd2675;

    // Register indexes past the end of the map; writes to them must be dropped.
    localparam logic [otx_pkg::CFG_IDX_W-1:0] REG_SPARE_A = otx_pkg::CFG_IDX_W'(6);
    localparam logic [otx_pkg::CFG_IDX_W-1:0] REG_SPARE_B = otx_pkg::CFG_IDX_W'(7);

    // Cycles without any transaction before the run is declared hung.
    localparam int QUIET_LIMIT = 5000;

    // One input item as the predictor sees it.
    typedef struct packed {
        logic                             cmd;
        logic [otx_pkg::SENDER_BITS-1:0]  sender;
        logic [otx_pkg::TARGET_BITS-1:0]  target;
        logic [otx_pkg::PAYLOAD_BITS-1:0] payload;
    } t_tx_item;

    // Predicted transmitter state: frame, symbol counter, phase, tick counter, line.
    typedef struct packed {
        logic [otx_pkg::FRAME_BITS-1:0] bits;
        logic [6:0]                     sym;
        otx_pkg::t_phase                phase;
        logic [otx_pkg::TICK_W-1:0]     ticks;
        logic                           line;
    } t_radio_state;

    logic                               i_clk;
    logic                               i_rst_n     = 1'b0;
    logic                               i_s_tvalid  = 1'b0;
    logic                               o_s_tready;
    logic [otx_pkg::IN_DATA_W-1:0]      i_s_tdata   = '0;
    logic                               i_s_tuser   = 1'b0;
    logic                               o_m_tvalid;
    logic                               i_m_tready  = 1'b0;
    logic [otx_pkg::OUT_DATA_W-1:0]     o_m_tdata;
    logic                               o_m_tlast;
    logic                               i_cfg_valid = 1'b0;
    logic                               o_cfg_ready;
    logic [otx_pkg::CFG_IDX_W-1:0]      i_cfg_index = '0;
    logic [otx_pkg::TICK_W-1:0]         i_cfg_data  = '0;

    ook_pulse_frame_transmitter uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tlast   (o_m_tlast),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // Items waiting to be sent, and the line samples predicted for accepted items.
    t_tx_item          tx_items_q[$];
    otx_pkg::t_result  predicted_line_q[$];

    // The predictor's copy of the timing registers, the state that tracks the
    // block transaction by transaction, and a look-ahead copy used to plan stimulus.
    otx_pkg::t_cfg     timing;
    t_radio_state      radio_live;
    t_radio_state      radio_plan;
    otx_pkg::t_result  step_res;
    otx_pkg::t_result  expected_res;

    // Items put on the bus and items taken by the block; they differ while one waits.
    int           offered_count = 0;
    int           accepted_count = 0;
    int           send_gap_pct = 0;
    int           recv_stall_pct = 0;
    int           mismatch_count = 0;
    int           quiet_cycles = 0;

    // Gap percentages of the four traffic phases: none, sender, receiver, both.
    int           gap_send [4] = '{0, 82, 0, 28};
    int           gap_recv [4] = '{0, 0, 82, 28};

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Advances a transmitter state by one item and returns the line sample that
    // the block must report for it. A start only takes effect while idle; a tick
    // counts up through the current segment and, on its last tick, moves the line to
    // the level of the next segment.
    function automatic otx_pkg::t_result radio_step(inout t_radio_state st,
                                                    input t_tx_item it);
        otx_pkg::t_result               r;
        int unsigned                    seg;
        int unsigned                    next_tick;
        logic                           data_bit;
        logic [otx_pkg::FRAME_BITS-1:0] f;
        r.frame_done = 1'b0;
        if (it.cmd == otx_pkg::CMD_START) begin
            if (st.phase == otx_pkg::PH_IDLE) begin
                // Each field goes in MSB first; the positions past the payload stay zero.
                f = '0;
                for (int i = 0; i < otx_pkg::SENDER_BITS; i++) begin
                    f[i] = it.sender[otx_pkg::SENDER_BITS-1-i];
                end
                for (int i = 0; i < otx_pkg::TARGET_BITS; i++) begin
                    f[otx_pkg::SENDER_BITS+i] = it.target[otx_pkg::TARGET_BITS-1-i];
                end
                for (int i = 0; i < otx_pkg::PAYLOAD_BITS; i++) begin
                    f[otx_pkg::SENDER_BITS+otx_pkg::TARGET_BITS+i] =
                        it.payload[otx_pkg::PAYLOAD_BITS-1-i];
                end
                st.bits  = f;
                st.sym   = '0;
                st.ticks = '0;
                st.phase = otx_pkg::PH_NOISE;
                st.line  = 1'b1;
            end
        end else if (st.phase != otx_pkg::PH_IDLE) begin
            // Even symbols send the frame bit, odd ones its complement.
            data_bit = st.bits[st.sym[6:1]] ^ st.sym[0];
            case (st.phase)
                otx_pkg::PH_NOISE, otx_pkg::PH_GAP_HIGH, otx_pkg::PH_TRAILER:
                    seg = 32'(timing.latch_high);
                otx_pkg::PH_LATCH1_LOW: seg = 32'(timing.latch1_low);
                otx_pkg::PH_LATCH2_LOW: seg = 32'(timing.latch2_low);
                otx_pkg::PH_DATA_HIGH:  seg = 32'(timing.pulse_high);
                otx_pkg::PH_DATA_LOW:
                    seg = data_bit ? 32'(timing.one_low) : 32'(timing.zero_low);
                default:                seg = 1;
            endcase
            // A zero length behaves like a single tick.
            if (seg == 0) begin
                seg = 1;
            end
            next_tick = st.ticks + 1;
            if (next_tick >= seg) begin
                st.ticks = '0;
                case (st.phase)
                    otx_pkg::PH_NOISE: begin
                        st.phase = otx_pkg::PH_LATCH1_LOW;
                        st.line  = 1'b0;
                    end
                    otx_pkg::PH_LATCH1_LOW: begin
                        st.phase = otx_pkg::PH_GAP_HIGH;
                        st.line  = 1'b1;
                    end
                    otx_pkg::PH_GAP_HIGH: begin
                        st.phase = otx_pkg::PH_LATCH2_LOW;
                        st.line  = 1'b0;
                    end
                    otx_pkg::PH_LATCH2_LOW: begin
                        st.phase = otx_pkg::PH_DATA_HIGH;
                        st.sym   = '0;
                        st.line  = 1'b1;
                    end
                    otx_pkg::PH_DATA_HIGH: begin
                        st.phase = otx_pkg::PH_DATA_LOW;
                        st.line  = 1'b0;
                    end
                    otx_pkg::PH_DATA_LOW: begin
                        if (st.sym + 1 >= 2 * otx_pkg::FRAME_BITS) begin
                            st.phase = otx_pkg::PH_TRAILER;
                            st.sym   = '0;
                        end else begin
                            st.phase = otx_pkg::PH_DATA_HIGH;
                            st.sym   = st.sym + 1'b1;
                        end
                        st.line = 1'b1;
                    end
                    default: begin
                        // The trailer has ended: back to idle, line low.
                        st.phase     = otx_pkg::PH_IDLE;
                        st.line      = 1'b0;
                        r.frame_done = 1'b1;
                    end
                endcase
            end else begin
                st.ticks = st.ticks + 1'b1;
            end
        end
        r.line_level = st.line;
        r.busy_res   = (st.phase != otx_pkg::PH_IDLE);
        return r;
    endfunction

    // Field values with a bias toward all zeros and all ones.
    function automatic logic [otx_pkg::PAYLOAD_BITS-1:0] pick_field(input int width);
        logic [otx_pkg::PAYLOAD_BITS-1:0] mask;
        mask = (otx_pkg::PAYLOAD_BITS'(1) << width) - 1'b1;
        case ($urandom_range(7))
            0:       return '0;
            1:       return mask;
            default: return otx_pkg::PAYLOAD_BITS'($urandom) & mask;
        endcase
    endfunction

    task automatic queue_one(input logic cmd, input logic [otx_pkg::SENDER_BITS-1:0] sender,
                             input logic [otx_pkg::TARGET_BITS-1:0] target,
                             input logic [otx_pkg::PAYLOAD_BITS-1:0] payload);
        t_tx_item it;
        it.cmd     = cmd;
        it.sender  = sender;
        it.target  = target;
        it.payload = payload;
        tx_items_q.push_back(it);
    endtask

    // Plans a run of items from the current state: while idle mostly a start with
    // the odd idle tick, while busy mostly ticks with the odd stray start.
    // Only called once everything sent so far has been checked.
    task automatic queue_items(input int count);
        t_tx_item it;
        radio_plan = radio_live;
        for (int n = 0; n < count; n++) begin
            if (radio_plan.phase == otx_pkg::PH_IDLE) begin
                it.cmd = ($urandom_range(3) == 0) ? otx_pkg::CMD_TICK : otx_pkg::CMD_START;
            end else begin
                it.cmd = ($urandom_range(29) == 0) ? otx_pkg::CMD_START : otx_pkg::CMD_TICK;
            end
            it.sender  = otx_pkg::SENDER_BITS'(pick_field(otx_pkg::SENDER_BITS));
            it.target  = otx_pkg::TARGET_BITS'(pick_field(otx_pkg::TARGET_BITS));
            it.payload = pick_field(otx_pkg::PAYLOAD_BITS);
            void'(radio_step(radio_plan, it));
            tx_items_q.push_back(it);
        end
    endtask

    // Holds the sender back until every item has gone in and every result is back.
    task automatic wait_quiet();
        while (tx_items_q.size() != 0 || predicted_line_q.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    // One write transaction on the register channel; the predictor takes the
    // new value at the edge the block accepts it.
    task automatic write_reg(input logic [otx_pkg::CFG_IDX_W-1:0] idx,
                             input logic [otx_pkg::TICK_W-1:0] val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do begin
            @(posedge i_clk);
        end while (!o_cfg_ready);
        case (idx)
            otx_pkg::REG_PULSE_HIGH: timing.pulse_high = val;
            otx_pkg::REG_ONE_LOW:    timing.one_low    = val;
            otx_pkg::REG_ZERO_LOW:   timing.zero_low   = val;
            otx_pkg::REG_LATCH_HIGH: timing.latch_high = val;
            otx_pkg::REG_LATCH1_LOW: timing.latch1_low = val;
            otx_pkg::REG_LATCH2_LOW: timing.latch2_low = val;
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // Short segments, at most five ticks each, keep whole frames brief; zero
    // is written now and then since it must act as one tick.
    function automatic logic [otx_pkg::TICK_W-1:0] pick_ticks();
        case ($urandom_range(9))
            0, 1:    return '0;
            8:       return 16'd2;
            9:       return otx_pkg::TICK_W'($urandom_range(5, 3));
            default: return 16'd1;
        endcase
    endfunction

    task automatic program_timing();
        write_reg(otx_pkg::REG_PULSE_HIGH, pick_ticks());
        write_reg(otx_pkg::REG_ONE_LOW,    pick_ticks());
        write_reg(otx_pkg::REG_ZERO_LOW,   pick_ticks());
        write_reg(otx_pkg::REG_LATCH_HIGH, pick_ticks());
        write_reg(otx_pkg::REG_LATCH1_LOW, pick_ticks());
        write_reg(otx_pkg::REG_LATCH2_LOW, pick_ticks());
        if ($urandom_range(1) == 0) begin
            write_reg(REG_SPARE_A, otx_pkg::TICK_W'($urandom));
        end else begin
            write_reg(REG_SPARE_B, otx_pkg::TICK_W'($urandom));
        end
    endtask

    // Main sequence: reset, a directed opening, then traffic phases under the
    // four idling patterns, each with two timing settings.
    initial begin
        timing.pulse_high = RST_PULSE_HIGH;
        timing.one_low    = RST_ONE_LOW;
        timing.zero_low   = RST_ZERO_LOW;
        timing.latch_high = RST_LATCH_HIGH;
        timing.latch1_low = RST_LATCH1_LOW;
        timing.latch2_low = RST_LATCH2_LOW;

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // A tick while idle must leave everything low. Then a frame of extreme
        // fields starts under the reset timing, and a second start while that
        // frame is running must be dropped.
        queue_one(otx_pkg::CMD_TICK, '1, '1, '1);
        queue_one(otx_pkg::CMD_START, '1, '0, '1);
        repeat (3) queue_one(otx_pkg::CMD_TICK, '0, '0, '0);
        queue_one(otx_pkg::CMD_START, '0, '1, '0);
        queue_one(otx_pkg::CMD_TICK, '1, '1, '1);
        wait_quiet();

        // Mid-frame writes take effect at the next compare: first the largest
        // lengths, which keep the noise pulse going...
        write_reg(otx_pkg::REG_PULSE_HIGH, '1);
        write_reg(otx_pkg::REG_ONE_LOW,    '1);
        write_reg(otx_pkg::REG_ZERO_LOW,   '1);
        write_reg(otx_pkg::REG_LATCH_HIGH, '1);
        write_reg(otx_pkg::REG_LATCH1_LOW, '1);
        write_reg(otx_pkg::REG_LATCH2_LOW, '1);
        repeat (3) queue_one(otx_pkg::CMD_TICK, '0, '1, '0);
        wait_quiet();

        // ...then the shortest ones, with a zero among them, so the counter
        // already past the new length ends the segment on the next tick.
        write_reg(otx_pkg::REG_PULSE_HIGH, 16'd1);
        write_reg(otx_pkg::REG_ONE_LOW,    16'd1);
        write_reg(otx_pkg::REG_ZERO_LOW,   '0);
        write_reg(otx_pkg::REG_LATCH_HIGH, 16'd1);
        write_reg(otx_pkg::REG_LATCH1_LOW, 16'd1);
        write_reg(otx_pkg::REG_LATCH2_LOW, '0);
        write_reg(REG_SPARE_A, '1);
        write_reg(REG_SPARE_B, '1);
        repeat (2) queue_one(otx_pkg::CMD_TICK, '1, '0, '1);
        wait_quiet();

        for (int m = 0; m < 4; m++) begin
            send_gap_pct   = gap_send[m];
            recv_stall_pct = gap_recv[m];
            program_timing();
            queue_items(64);
            wait_quiet();
            // The second setting usually lands in the middle of a frame.
            program_timing();
            queue_items(64);
            wait_quiet();
        end

        // Let the block run on idle so it can show any result nobody asked for.
        repeat (8) @(posedge i_clk);
        if (mismatch_count == 0 && predicted_line_q.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    // Driver: presents the oldest pending item at the falling edge and holds
    // it until the transaction completes; gaps are drawn only between items.
    always @(negedge i_clk) begin
        if (offered_count == accepted_count) begin
            if (i_rst_n && tx_items_q.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
                i_s_tvalid    <= 1'b1;
                i_s_tuser     <= tx_items_q[0].cmd;
                i_s_tdata     <= otx_pkg::IN_DATA_W'({tx_items_q[0].payload,
                                                     tx_items_q[0].target,
                                                     tx_items_q[0].sender});
                offered_count <= offered_count + 1;
            end else begin
                i_s_tvalid <= 1'b0;
            end
        end
    end

    // Each accepted input transaction is run through the predictor right away,
    // so the expected line samples stay in acceptance order.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            radio_live.bits  = '0;
            radio_live.sym   = '0;
            radio_live.phase = otx_pkg::PH_IDLE;
            radio_live.ticks = '0;
            radio_live.line  = 1'b0;
        end else if (i_s_tvalid && o_s_tready) begin
            step_res = radio_step(radio_live, tx_items_q[0]);
            predicted_line_q.push_back(step_res);
            void'(tx_items_q.pop_front());
            accepted_count <= accepted_count + 1;
        end
    end

    // Receiver back-pressure, redrawn every cycle.
    always @(negedge i_clk) begin
        i_m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Monitor: every output transaction is checked against the oldest prediction.
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (predicted_line_q.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10) begin
                    $display("unexpected result: line %0b busy %0b done %0b",
                             o_m_tdata[0], o_m_tdata[1], o_m_tlast);
                end
            end else begin
                expected_res = predicted_line_q.pop_front();
                if (o_m_tdata[0] !== expected_res.line_level
                        || o_m_tdata[1] !== expected_res.busy_res
                        || o_m_tlast !== expected_res.frame_done) begin
                    mismatch_count++;
                    if (mismatch_count <= 10) begin
                        $display("mismatch: line %0b/%0b busy %0b/%0b done %0b/%0b (exp/act)",
                                 expected_res.line_level, o_m_tdata[0], expected_res.busy_res,
                                 o_m_tdata[1], expected_res.frame_done, o_m_tlast);
                    end
                end
            end
        end
    end

    // Watchdog: any transaction on any channel restarts the count.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)
                || (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

endmodule
